// ----- src/ksbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbc_pkg: shared types and constants of the keyed substitution byte cipher
// payload structs, action codes, controller states and control bundles
// ----------------------------------------------------------------------------
package ksbc_pkg;

    localparam int KEY_MAX_DEF = 64;   // default key store depth
    localparam int TABLE_SIZE  = 256;  // substitution table depth
    localparam int BYTE_W      = 8;
    localparam int KEY_SLOT_W  = 6;
    localparam int KEY_LEN_W   = 7;
    localparam int LEN_W       = 9;    // holds any length up to 256

    typedef enum logic [1:0] {
        ACT_LOAD_KEY = 2'd0,
        ACT_BUILD    = 2'd1,
        ACT_ENCRYPT  = 2'd2,
        ACT_DECRYPT  = 2'd3
    } action_t;

    typedef struct packed {
        action_t                 action;
        logic [BYTE_W-1:0]       data_byte;
        logic [KEY_SLOT_W-1:0]   key_slot;
        logic                    new_message;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]       result_byte;
        logic                    table_ready;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHAIN_RD,
        ST_ENC,
        ST_FILL,
        ST_SWAP_KEY,
        ST_SWAP_RD,
        ST_SWAP_WR1,
        ST_SWAP_WR2,
        ST_INV_RD,
        ST_INV_WR,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath strobes, at most one high per cycle
    typedef struct packed {
        logic accept;
        logic decode;
        logic chain_rd;
        logic enc;
        logic fill;
        logic swap_rd;
        logic swap_wr1;
        logic swap_wr2;
        logic inv_rd;
        logic inv_wr;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    idx_last;
        logic    out_free;
    } dp_status_t;

endpackage

// ----- src/ksbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbc_ctrl: sequencing state machine
// walks one request at a time through decode, cipher or table build steps
// ----------------------------------------------------------------------------
module ksbc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ksbc_pkg::dp_status_t  status,
    output ksbc_pkg::ctrl_cmd_t   cmd
);

    ksbc_pkg::ctrl_state_t state_reg;
    ksbc_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksbc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ksbc_pkg::ST_DECODE;
                end
            end
            ksbc_pkg::ST_DECODE: begin
                case (status.action)
                    ksbc_pkg::ACT_LOAD_KEY: state_next = ksbc_pkg::ST_DONE;
                    ksbc_pkg::ACT_BUILD:    state_next = ksbc_pkg::ST_FILL;
                    default:                state_next = ksbc_pkg::ST_CHAIN_RD;
                endcase
            end
            ksbc_pkg::ST_CHAIN_RD: begin
                if (status.action == ksbc_pkg::ACT_ENCRYPT) begin
                    state_next = ksbc_pkg::ST_ENC;
                end else begin
                    state_next = ksbc_pkg::ST_DONE;
                end
            end
            ksbc_pkg::ST_ENC: state_next = ksbc_pkg::ST_DONE;
            ksbc_pkg::ST_FILL: begin
                if (status.idx_last) begin
                    state_next = ksbc_pkg::ST_SWAP_KEY;
                end
            end
            ksbc_pkg::ST_SWAP_KEY: state_next = ksbc_pkg::ST_SWAP_RD;
            ksbc_pkg::ST_SWAP_RD:  state_next = ksbc_pkg::ST_SWAP_WR1;
            ksbc_pkg::ST_SWAP_WR1: state_next = ksbc_pkg::ST_SWAP_WR2;
            ksbc_pkg::ST_SWAP_WR2: begin
                if (status.idx_last) begin
                    state_next = ksbc_pkg::ST_INV_RD;
                end else begin
                    state_next = ksbc_pkg::ST_SWAP_KEY;
                end
            end
            ksbc_pkg::ST_INV_RD: state_next = ksbc_pkg::ST_INV_WR;
            ksbc_pkg::ST_INV_WR: begin
                if (status.idx_last) begin
                    state_next = ksbc_pkg::ST_DONE;
                end else begin
                    state_next = ksbc_pkg::ST_INV_RD;
                end
            end
            ksbc_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = ksbc_pkg::ST_IDLE;
                end
            end
            default: state_next = ksbc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ksbc_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ksbc_pkg::ST_DECODE:   cmd.decode   = 1'b1;
            ksbc_pkg::ST_CHAIN_RD: cmd.chain_rd = 1'b1;
            ksbc_pkg::ST_ENC:      cmd.enc      = 1'b1;
            ksbc_pkg::ST_FILL:     cmd.fill     = 1'b1;
            ksbc_pkg::ST_SWAP_RD:  cmd.swap_rd  = 1'b1;
            ksbc_pkg::ST_SWAP_WR1: cmd.swap_wr1 = 1'b1;
            ksbc_pkg::ST_SWAP_WR2: cmd.swap_wr2 = 1'b1;
            ksbc_pkg::ST_INV_RD:   cmd.inv_rd   = 1'b1;
            ksbc_pkg::ST_INV_WR:   cmd.inv_wr   = 1'b1;
            ksbc_pkg::ST_DONE:     cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- src/ksbc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbc_datapath: key, chain and table memories with chaining registers
// executes the controller strobes and holds the result register
// ----------------------------------------------------------------------------
module ksbc_datapath #(
    parameter int KEY_MAX = ksbc_pkg::KEY_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [ksbc_pkg::KEY_LEN_W-1:0]     cfg_data,
    input  ksbc_pkg::in_item_t                 s_data,
    input  logic                               m_ready,
    output logic                               m_valid,
    output ksbc_pkg::out_item_t                m_data,
    input  ksbc_pkg::ctrl_cmd_t                cmd,
    output ksbc_pkg::dp_status_t               status
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = ksbc_pkg::LEN_W;
    localparam int BW = ksbc_pkg::BYTE_W;
    localparam logic [LW-1:0] KMAX_L = LW'(KEY_MAX);

    // memories
    logic [BW-1:0] key_mem   [KEY_MAX];
    logic [BW-1:0] chain_mem [KEY_MAX];
    logic [BW-1:0] fwd_mem   [ksbc_pkg::TABLE_SIZE];
    logic [BW-1:0] inv_mem   [ksbc_pkg::TABLE_SIZE];

    logic [BW-1:0] key_rdata_reg;
    logic [BW-1:0] chain_rdata_reg;
    logic [BW-1:0] fwd_rdata_a_reg;
    logic [BW-1:0] fwd_rdata_b_reg;
    logic [BW-1:0] inv_rdata_reg;

    // registers
    ksbc_pkg::in_item_t              item_reg;
    logic [ksbc_pkg::KEY_LEN_W-1:0]  key_length_reg;
    logic [KW-1:0]                   pos_reg, pos_next;
    logic                            first_reg, first_next;
    logic                            built_reg, built_next;
    logic [BW-1:0]                   idx_reg, idx_next;
    logic [KW-1:0]                   k_reg, k_next;
    logic [BW-1:0]                   j_reg, j_next;
    logic [BW-1:0]                   t_reg, t_next;
    logic [BW-1:0]                   result_reg, result_next;
    logic                            m_valid_reg, m_valid_next;
    ksbc_pkg::out_item_t             m_data_reg;

    // memory controls
    logic          key_we;
    logic          chain_we;
    logic [KW-1:0] chain_raddr;
    logic [BW-1:0] chain_wdata;
    logic          fwd_we;
    logic [BW-1:0] fwd_waddr, fwd_wdata, fwd_raddr_a, fwd_raddr_b;
    logic          inv_we;

    logic [LW-1:0] len_ext;
    logic [LW-1:0] n_used;
    logic          is_cipher;
    logic          slot_ok;
    logic [KW-1:0] pos_eff;
    logic          first_eff;
    logic [BW-1:0] prev;
    logic [LW-1:0] pos_plus;
    logic [LW-1:0] k_plus;
    logic          out_free;

    assign len_ext   = LW'(key_length_reg);
    assign n_used    = (len_ext == '0) ? LW'(1) : ((len_ext > KMAX_L) ? KMAX_L : len_ext);
    assign is_cipher = (item_reg.action == ksbc_pkg::ACT_ENCRYPT) ||
                       (item_reg.action == ksbc_pkg::ACT_DECRYPT);
    assign slot_ok   = (LW'(item_reg.key_slot) < KMAX_L);
    assign prev      = first_reg ? '0 : chain_rdata_reg;
    assign pos_plus  = LW'(pos_reg) + LW'(1);
    assign k_plus    = LW'(k_reg) + LW'(1);
    assign out_free  = !m_valid_reg || m_ready;

    // restart first, then wrap a position left beyond a shortened block
    always_comb begin
        pos_eff   = item_reg.new_message ? '0 : pos_reg;
        first_eff = item_reg.new_message ? 1'b1 : first_reg;
        if (is_cipher && (LW'(pos_eff) >= n_used)) begin
            pos_eff   = '0;
            first_eff = 1'b0;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        first_next   = first_reg;
        built_next   = built_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        key_we       = 1'b0;
        chain_we     = 1'b0;
        chain_raddr  = pos_reg;
        chain_wdata  = item_reg.data_byte;
        fwd_we       = 1'b0;
        fwd_waddr    = idx_reg;
        fwd_wdata    = idx_reg;
        fwd_raddr_a  = idx_reg;
        fwd_raddr_b  = key_rdata_reg;
        inv_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.decode) begin
            pos_next    = pos_eff;
            first_next  = first_eff;
            chain_raddr = pos_eff;
            idx_next    = '0;
            result_next = '0;
            key_we      = (item_reg.action == ksbc_pkg::ACT_LOAD_KEY) && slot_ok;
        end

        if (cmd.chain_rd) begin
            if (item_reg.action == ksbc_pkg::ACT_ENCRYPT) begin
                fwd_raddr_a = item_reg.data_byte ^ prev;
            end else begin
                result_next = inv_rdata_reg ^ prev;
                chain_we    = 1'b1;
            end
        end

        if (cmd.enc) begin
            result_next = fwd_rdata_a_reg;
            chain_wdata = fwd_rdata_a_reg;
            chain_we    = 1'b1;
        end

        // block position advances with every stored chain byte
        if (chain_we) begin
            if (pos_plus >= n_used) begin
                pos_next   = '0;
                first_next = 1'b0;
            end else begin
                pos_next = pos_plus[KW-1:0];
            end
        end

        if (cmd.fill) begin
            fwd_we   = 1'b1;
            idx_next = idx_reg + BW'(1);
            k_next   = '0;
        end

        if (cmd.swap_rd) begin
            j_next = key_rdata_reg;
        end

        if (cmd.swap_wr1) begin
            fwd_we    = 1'b1;
            fwd_waddr = j_reg;
            fwd_wdata = fwd_rdata_a_reg;
            t_next    = fwd_rdata_b_reg;
        end

        if (cmd.swap_wr2) begin
            fwd_we    = 1'b1;
            fwd_wdata = t_reg;
            idx_next  = idx_reg + BW'(1);
            k_next    = (k_plus >= n_used) ? '0 : k_plus[KW-1:0];
        end

        // forward entry whose index goes into the inverse table
        if (cmd.inv_rd) begin
            fwd_raddr_a = idx_reg;
        end

        if (cmd.inv_wr) begin
            inv_we   = 1'b1;
            idx_next = idx_reg + BW'(1);
            if (idx_reg == '1) begin
                built_next = 1'b1;
            end
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= ksbc_pkg::KEY_LEN_W'(1);
            pos_reg        <= '0;
            first_reg      <= 1'b1;
            built_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                key_length_reg <= cfg_data;
            end
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.out_load) begin
            m_data_reg.result_byte <= result_reg;
            m_data_reg.table_ready <= built_reg;
        end
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        t_reg      <= t_next;
        result_reg <= result_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[KW'(item_reg.key_slot)] <= item_reg.data_byte;
        end
        key_rdata_reg <= key_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (chain_we) begin
            chain_mem[pos_reg] <= chain_wdata;
        end
        chain_rdata_reg <= chain_mem[chain_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        fwd_rdata_a_reg <= fwd_mem[fwd_raddr_a];
        fwd_rdata_b_reg <= fwd_mem[fwd_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[fwd_rdata_a_reg] <= idx_reg;
        end
        inv_rdata_reg <= inv_mem[item_reg.data_byte];
    end

    assign status.action   = item_reg.action;
    assign status.idx_last = (idx_reg == '1);
    assign status.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/keyed_sbox_cbc_byte_cipher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sbox_cbc_byte_cipher_top: keyed substitution byte cipher with chaining
// top level joining the sequencing controller and the memory datapath
// ----------------------------------------------------------------------------
// One request in, one response out. A request loads a key byte into a slot,
// builds the substitution and inverse tables from the loaded key, or
// encrypts or decrypts one byte with chaining over blocks as long as the
// key. The block works on one request at a time and takes the next request
// only after the current one has loaded its response. Each request runs a
// decode step and ends by loading its response; a decrypt adds a chain
// store read between them and an encrypt a chain store read and a table
// read, set by the dependent registered reads of the chain store and the
// tables. A table build decodes, seeds the forward table with the identity,
// makes 256 swaps, each with the registered key and table reads and the two
// writes through the single write port, then writes the inverse table entry
// by entry and loads the response. A finished response waits in the output
// register while the next request can already be taken; a later response
// then holds the controller until that register frees. The user must write
// the key length register through the cfg port only while no request is in
// flight; the block itself does not enforce it. A new_message request
// restarts chaining with an all-zero IV.
// ----------------------------------------------------------------------------
module keyed_sbox_cbc_byte_cipher_top #(
    parameter int KEY_MAX = ksbc_pkg::KEY_MAX_DEF  // key store depth, 1 to 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // key length register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ksbc_pkg::KEY_LEN_W-1:0]  cfg_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ksbc_pkg::in_item_t              s_data,
    // response channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output ksbc_pkg::out_item_t             m_data
);

    ksbc_pkg::ctrl_cmd_t  cmd;
    ksbc_pkg::dp_status_t status;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // state machine: which step of the current request runs this cycle
    ksbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // memories, chaining state and the response register
    ksbc_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
